// ===== rtl/core/fppd_pkg.sv =====
// Shared types and constants for the flow pulse pour detector.
// No dependencies; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package fppd_pkg;

    localparam int TIME_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int NOW_WIDTH   = 32;
    localparam int TOTAL_WIDTH = 32;
    localparam int DUR_WIDTH   = 32;
    localparam int KIND_WIDTH  = 2;

    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POUR_DELAY = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_POUR   = 1'd1;

    localparam logic [CFG_DATA_WIDTH-1:0] POUR_DELAY_RESET = 16'd1000;
    localparam logic [CFG_DATA_WIDTH-1:0] MIN_POUR_RESET   = 16'd100;

    localparam logic ACT_PULSE = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    typedef enum logic [KIND_WIDTH-1:0] {
        EV_POURING   = 2'd0,
        EV_NO_POUR   = 2'd1,
        EV_POUR_DONE = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic                 action;
        logic [NOW_WIDTH-1:0] now_ms;
    } item_t;

    typedef struct packed {
        event_kind_t            kind;
        logic [TOTAL_WIDTH-1:0] total;
        logic [DUR_WIDTH-1:0]   duration;
    } result_t;

endpackage

// ===== rtl/core/flow_pulse_pour_detector.sv =====
// Top level of the flow pulse pour detector: input register, session stage, output register.
// Depends on fppd_pkg, fppd_in_reg, fppd_session and fppd_out_reg.
// A request that gives a result passes the input register, then the output register.
// Throughput: one request per cycle; a full output register that is not taken holds the stage.
// Reset clears the counts, session times and handshake state; registers return to 1000 and 100.
`timescale 1ns / 1ps

module flow_pulse_pour_detector
#(
    parameter int TIME_WIDTH  = fppd_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = fppd_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    action,
    input  logic [fppd_pkg::NOW_WIDTH-1:0]          now_ms,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [fppd_pkg::KIND_WIDTH-1:0]         event_kind,
    output logic [fppd_pkg::TOTAL_WIDTH-1:0]        pulse_total,
    output logic [fppd_pkg::DUR_WIDTH-1:0]          duration_ms,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [fppd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [fppd_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

    logic              item_valid;
    fppd_pkg::item_t   item;
    logic              can_advance;
    logic              advance;
    logic              has_result;
    fppd_pkg::result_t result;
    fppd_pkg::result_t held;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid && can_advance;

    fppd_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .now_ms     (now_ms),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    fppd_session #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_session
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .advance    (advance),
        .item       (item),
        .has_result (has_result),
        .result     (result)
    );

    fppd_out_reg u_out_reg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && has_result),
        .result      (result),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .can_advance (can_advance),
        .held        (held)
    );

    assign event_kind  = held.kind;
    assign pulse_total = held.total;
    assign duration_ms = held.duration;

endmodule

// ===== rtl/core/fppd_in_reg.sv =====
// Input register stage of the pour detector: holds one request for the session stage.
// Uses fppd_pkg for the item type.
`timescale 1ns / 1ps

module fppd_in_reg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic [fppd_pkg::NOW_WIDTH-1:0]    now_ms,
    input  logic                              advance,
    output logic                              item_valid,
    output fppd_pkg::item_t                   item
);

    logic            valid_reg;
    logic            valid_next;
    fppd_pkg::item_t item_reg;

    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.action <= action;
            item_reg.now_ms <= now_ms;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/fppd_session.sv =====
// Session stage: pulse counter, session timing state and configuration registers.
// Uses fppd_pkg for item, result and register index definitions.
`timescale 1ns / 1ps

module fppd_session
#(
    parameter int TIME_WIDTH  = fppd_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = fppd_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [fppd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [fppd_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    input  logic                                    advance,
    input  fppd_pkg::item_t                         item,
    output logic                                    has_result,
    output fppd_pkg::result_t                       result
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [fppd_pkg::CFG_DATA_WIDTH-1:0] pour_delay_reg;
    logic [fppd_pkg::CFG_DATA_WIDTH-1:0] min_pour_reg;

    logic [COUNT_WIDTH-1:0] raw_reg,     raw_next;
    logic [COUNT_WIDTH-1:0] seen_reg,    seen_next;
    logic                   started_reg, started_next;
    logic [TIME_WIDTH-1:0]  start_reg,   start_next;
    logic [TIME_WIDTH-1:0]  last_reg,    last_next;

    logic [TIME_WIDTH-1:0]  now;
    logic [TIME_WIDTH-1:0]  start_eff;
    logic [TIME_WIDTH-1:0]  idle_time;
    logic [TIME_WIDTH-1:0]  dur;

    assign now       = TIME_WIDTH'(item.now_ms);
    assign start_eff = started_reg ? start_reg : now;
    assign idle_time = now - last_reg;
    assign dur       = now - start_eff;

    always_comb
    begin
        raw_next        = raw_reg;
        seen_next       = seen_reg;
        started_next    = started_reg;
        start_next      = start_reg;
        last_next       = last_reg;
        has_result      = 1'b0;
        result.kind     = fppd_pkg::EV_POURING;
        result.total    = fppd_pkg::TOTAL_WIDTH'(seen_reg);
        result.duration = '0;

        if (item.action == fppd_pkg::ACT_PULSE)
        begin
            // saturate at all ones
            if (raw_reg != COUNT_MAX)
            begin
                raw_next = raw_reg + 1'b1;
            end
        end
        else if (raw_reg != '0)
        begin
            started_next = 1'b1;
            start_next   = start_eff;
            if (raw_reg > seen_reg)
            begin
                last_next    = now;
                seen_next    = raw_reg;
                has_result   = 1'b1;
                result.total = fppd_pkg::TOTAL_WIDTH'(raw_reg);
            end
            else if (idle_time > TIME_WIDTH'(pour_delay_reg))
            begin
                has_result = 1'b1;
                if (fppd_pkg::TOTAL_WIDTH'(seen_reg) < fppd_pkg::TOTAL_WIDTH'(min_pour_reg))
                begin
                    result.kind = fppd_pkg::EV_NO_POUR;
                end
                else
                begin
                    result.kind     = fppd_pkg::EV_POUR_DONE;
                    result.duration = fppd_pkg::DUR_WIDTH'(dur);
                end
                // end of session: drop all counts and times
                raw_next     = '0;
                seen_next    = '0;
                started_next = 1'b0;
                start_next   = '0;
                last_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg     <= '0;
            seen_reg    <= '0;
            started_reg <= 1'b0;
            start_reg   <= '0;
            last_reg    <= '0;
        end
        else if (advance)
        begin
            raw_reg     <= raw_next;
            seen_reg    <= seen_next;
            started_reg <= started_next;
            start_reg   <= start_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pour_delay_reg <= fppd_pkg::POUR_DELAY_RESET;
            min_pour_reg   <= fppd_pkg::MIN_POUR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fppd_pkg::REG_POUR_DELAY: pour_delay_reg <= cfg_data;
                fppd_pkg::REG_MIN_POUR:   min_pour_reg   <= cfg_data;
                default:                  ;
            endcase
        end
    end

endmodule

// ===== rtl/core/fppd_out_reg.sv =====
// Output register of the pour detector: holds one result request until taken.
// Uses fppd_pkg for the result type.
`timescale 1ns / 1ps

module fppd_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  fppd_pkg::result_t   result,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                can_advance,
    output fppd_pkg::result_t   held
);

    logic              valid_reg;
    logic              valid_next;
    fppd_pkg::result_t data_reg;

    assign can_advance = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule

// ===== rtl/core/fppd_checker.sv =====
// Port-level checks for the flow pulse pour detector, bound to the top level.
// Depends on fppd_pkg and flow_pulse_pour_detector.
`timescale 1ns / 1ps

module fppd_checker
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic                                    action,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic [fppd_pkg::KIND_WIDTH-1:0]         event_kind,
    input  logic [fppd_pkg::TOTAL_WIDTH-1:0]        pulse_total,
    input  logic [fppd_pkg::DUR_WIDTH-1:0]          duration_ms
);

    // hold a stalled result request
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind)
            && $stable(pulse_total) && $stable(duration_ms))
        else $error("stalled result changed");

    a_dur_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != fppd_pkg::EV_POUR_DONE |-> duration_ms == '0)
        else $error("duration set outside pour complete");

    // every session holds at least one pulse
    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pulse_total != '0)
        else $error("result with zero pulse total");

    // a fresh result comes from an accepted check, through the input and output registers
    a_rose_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && action == fppd_pkg::ACT_CHECK, 2))
        else $error("result without a preceding check");

endmodule

bind flow_pulse_pour_detector fppd_checker u_fppd_checker (.*);
